>>> src/lbqe_pkg.sv
// Shared types and constants for the link bandwidth queue emulator.
// Used by every module under src; depends on nothing.
package lbqe_pkg;

    localparam logic [23:0] BUDGET_MIN_BYTES = 24'd50;
    localparam logic [9:0]  MS_PER_SECOND    = 10'd1000;

    typedef enum logic [2:0] {
        REG_LOSS_THRESHOLD   = 3'd0,
        REG_RATE_KBPS        = 3'd1,
        REG_BYTES_PER_TICK   = 3'd2,
        REG_QUEUE_LIMIT      = 3'd3,
        REG_TICKS_PER_SECOND = 3'd4,
        REG_PROP_DELAY_TICKS = 3'd5,
        REG_INCLUDE_DELAY    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_LOSS  = 2'd1,
        CAUSE_QFULL = 2'd2
    } t_cause;

    typedef enum logic [1:0] {
        KIND_AGE   = 2'd0,
        KIND_LOSS  = 2'd1,
        KIND_ZRATE = 2'd2,
        KIND_ARR   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [30:0] loss_threshold;
        logic [23:0] rate_kbps;
        logic [23:0] bytes_per_tick;
        logic [8:0]  queue_limit;
        logic [15:0] ticks_per_second;
        logic [15:0] prop_delay_ticks;
        logic        include_delay;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] now_tick;
        logic [15:0] packet_len;
    } t_item;

    typedef struct packed {
        logic        dropped;
        t_cause      drop_cause;
        logic [31:0] schedule_tick;
        logic        zero_delay;
    } t_result;

endpackage

>>> src/lbqe_front.sv
// Front end: accepts input words, classifies them and holds them in a two-entry queue.
// Depends on lbqe_pkg.
module lbqe_front
    import lbqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [79:0] i_data,
    input  logic        i_func,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item      r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    t_item      item;
    logic       push, pop;

    always_comb begin
        item.now_tick   = i_data[31:0];
        item.packet_len = i_data[47:32];
        if (i_func) begin
            item.kind = KIND_AGE;
        end else if (i_cfg.loss_threshold != '0 && i_data[78:48] < i_cfg.loss_threshold) begin
            item.kind = KIND_LOSS;
        end else if (i_cfg.rate_kbps == '0) begin
            item.kind = KIND_ZRATE;
        end else begin
            item.kind = KIND_ARR;
        end
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_q[r_wptr] <= item;
    end

endmodule

>>> src/lbqe_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lbqe_pkg only through the common import convention.
module lbqe_div
    import lbqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [33:0] o_rem
);

    logic [33:0] r_rem, r_den;
    logic [31:0] r_quo;
    logic [4:0]  r_step;
    logic        r_busy, r_done;
    logic [34:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[31]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? 34'(trial - {1'b0, r_den}) : trial[33:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> src/lbqe_back.sv
// Back end: ages the exit-tick ring, computes link delay and holds the result register.
// Depends on lbqe_pkg and lbqe_div.
module lbqe_back
    import lbqe_pkg::*;
#(
    parameter int QUEUE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result,
    output logic [$clog2(QUEUE_SLOTS+1)-1:0] o_depth,
    output logic [23:0] o_bytes
);

    localparam int IDX_W = $clog2(QUEUE_SLOTS);
    localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int QW    = (CNT_W > 9) ? CNT_W : 9;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_AGE_RD  = 12'b0000_0000_0010,
        S_AGE_CHK = 12'b0000_0000_0100,
        S_AGED    = 12'b0000_0000_1000,
        S_TMOD    = 12'b0000_0001_0000,
        S_TRD     = 12'b0000_0010_0000,
        S_TGET    = 12'b0000_0100_0000,
        S_CALC    = 12'b0000_1000_0000,
        S_DGO     = 12'b0001_0000_0000,
        S_DIV     = 12'b0010_0000_0000,
        S_NMOD    = 12'b0100_0000_0000,
        S_WRITE   = 12'b1000_0000_0000
    } t_state;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [23:0]        r_bytes, n_bytes;
    logic [23:0]        r_left, n_left;
    logic [31:0]        r_tail, n_tail;
    logic [IDX_W-1:0]   r_mod, n_mod;
    logic [31:0]        r_num, n_num;
    logic [33:0]        r_den, n_den;
    logic               r_budget, n_budget;
    logic               r_used, n_used;
    logic               r_zdel, n_zdel;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;
    logic [CNT_W-1:0]   r_out_depth, n_out_depth;
    logic [23:0]        r_out_bytes, n_out_bytes;
    logic [QUEUE_SLOTS-1:0] r_vld;

    logic [31:0]        exit_mem [QUEUE_SLOTS];
    logic [15:0]        len_mem  [QUEUE_SLOTS];
    logic [31:0]        r_rd_tick;
    logic [15:0]        r_rd_len;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we, clr_head;

    logic [CNT_W-1:0]   lim;
    logic [QW-1:0]      ql_ext;
    logic [CNT_W-1:0]   head_inc;
    logic [31:0]        rd_tick, rd_len32;
    logic [31:0]        delay_add, bw;
    logic [15:0]        len2;

    logic               div_start, div_busy, div_done;
    logic [31:0]        div_num, div_quot;
    logic [33:0]        div_den, div_rem;

    lbqe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_comb begin
        ql_ext = QW'(i_cfg.queue_limit);
        if (ql_ext == '0) begin
            lim = CNT_W'(1);
        end else if (ql_ext > QW'(QUEUE_SLOTS)) begin
            lim = CNT_W'(QUEUE_SLOTS);
        end else begin
            lim = CNT_W'(ql_ext);
        end
    end

    assign head_inc  = CNT_W'(r_head) + CNT_W'(1);
    assign rd_tick   = r_rd_vld ? r_rd_tick : 32'd0;
    assign rd_len32  = r_rd_vld ? 32'(r_rd_len) : 32'd0;
    assign delay_add = i_cfg.include_delay ? 32'(i_cfg.prop_delay_ticks) : 32'd0;
    assign rd_addr   = (r_state == S_TRD) ? r_mod : r_head;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_head      = r_head;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_left      = r_left;
        n_tail      = r_tail;
        n_mod       = r_mod;
        n_num       = r_num;
        n_den       = r_den;
        n_budget    = r_budget;
        n_used      = r_used;
        n_zdel      = r_zdel;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        n_out_depth = r_out_depth;
        n_out_bytes = r_out_bytes;
        o_pop       = 1'b0;
        div_start   = 1'b0;
        div_num     = r_num;
        div_den     = r_den;
        mem_we      = 1'b0;
        clr_head    = 1'b0;
        len2        = r_item.packet_len;
        bw          = div_quot;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && !r_out_valid) begin
                    o_pop       = 1'b1;
                    n_item      = i_item;
                    n_out       = '0;
                    n_out_depth = r_count;
                    n_out_bytes = r_bytes;
                    unique case (i_item.kind)
                        KIND_LOSS: begin
                            n_out.dropped    = 1'b1;
                            n_out.drop_cause = CAUSE_LOSS;
                            n_out_valid      = 1'b1;
                        end
                        KIND_ZRATE: begin
                            n_out.schedule_tick = i_item.now_tick + delay_add;
                            n_out_valid         = 1'b1;
                        end
                        KIND_AGE, KIND_ARR: n_state = S_AGE_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_AGE_RD: begin
                n_state = (r_count == '0) ? S_AGED : S_AGE_CHK;
            end
            S_AGE_CHK: begin
                if (rd_tick < r_item.now_tick) begin
                    clr_head = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                    n_bytes  = r_bytes - rd_len32[23:0];
                    n_head   = (head_inc >= lim) ? '0 : IDX_W'(head_inc);
                    n_state  = S_AGE_RD;
                end else begin
                    n_state = S_AGED;
                end
            end
            S_AGED: begin
                n_out       = '0;
                n_out_depth = r_count;
                n_out_bytes = r_bytes;
                if (r_item.kind == KIND_AGE) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_count >= lim) begin
                    n_out.dropped    = 1'b1;
                    n_out.drop_cause = CAUSE_QFULL;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_count != '0) begin
                    div_start = 1'b1;
                    div_num   = 32'(r_head) + 32'(r_count) - 32'd1;
                    div_den   = 34'(lim);
                    n_state   = S_TMOD;
                end else begin
                    n_tail  = r_item.now_tick;
                    n_left  = '0;
                    n_state = S_CALC;
                end
            end
            S_TMOD: begin
                if (div_done) begin
                    n_mod   = div_rem[IDX_W-1:0];
                    n_state = S_TRD;
                end
            end
            S_TRD: n_state = S_TGET;
            S_TGET: begin
                n_tail  = rd_tick;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_used = 1'b0;
                if (r_left > 24'(r_item.packet_len)) begin
                    n_left = r_left - 24'(r_item.packet_len);
                    len2   = '0;
                end else if (r_left != '0) begin
                    len2   = r_item.packet_len - r_left[15:0];
                    n_used = 1'b1;
                    n_left = '0;
                end
                n_budget = (len2 != '0) && (i_cfg.bytes_per_tick > BUDGET_MIN_BYTES);
                if (n_budget) begin
                    n_num = 32'(len2);
                    n_den = 34'(i_cfg.bytes_per_tick);
                end else begin
                    n_num = 32'(len2) * 32'(i_cfg.ticks_per_second);
                    n_den = 34'(i_cfg.rate_kbps) * 34'(MS_PER_SECOND);
                end
                n_state = S_DGO;
            end
            S_DGO: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_budget) begin
                        bw = div_quot + 32'(r_used);
                        if (div_rem != '0) begin
                            n_left = i_cfg.bytes_per_tick - div_rem[23:0];
                        end
                    end
                    n_tail    = r_tail + bw;
                    n_zdel    = (bw == '0);
                    div_start = 1'b1;
                    div_num   = 32'(r_head) + 32'(r_count);
                    div_den   = 34'(lim);
                    n_state   = S_NMOD;
                end
            end
            S_NMOD: begin
                if (div_done) begin
                    n_mod   = div_rem[IDX_W-1:0];
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                mem_we              = 1'b1;
                n_count             = r_count + CNT_W'(1);
                n_bytes             = r_bytes + 24'(r_item.packet_len);
                n_out               = '0;
                n_out.schedule_tick = r_tail + delay_add;
                n_out.zero_delay    = r_zdel;
                n_out_depth         = n_count;
                n_out_bytes         = n_bytes;
                n_out_valid         = 1'b1;
                n_state             = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (clr_head) r_vld[r_head] <= 1'b0;
            if (mem_we)   r_vld[r_mod]  <= 1'b1;
        end
        r_item      <= n_item;
        r_tail      <= n_tail;
        r_mod       <= n_mod;
        r_num       <= n_num;
        r_den       <= n_den;
        r_budget    <= n_budget;
        r_used      <= n_used;
        r_zdel      <= n_zdel;
        r_out       <= n_out;
        r_out_depth <= n_out_depth;
        r_out_bytes <= n_out_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            exit_mem[r_mod] <= r_tail;
            len_mem[r_mod]  <= r_item.packet_len;
        end
        r_rd_tick <= exit_mem[rd_addr];
        r_rd_len  <= len_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_depth  = r_out_depth;
    assign o_bytes  = r_out_bytes;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_SLOTS))
        else $error("ring occupancy above capacity");
    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result register full while an item is in work");
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_count < lim))
        else $error("append into a full ring");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

>>> src/link_bandwidth_queue_emulator.sv
// Path, input accept to result: loss and zero-rate words are answered straight from the idle state;
// an age word or a queue-full drop first drains the aged slots from the ring;
// an arrival also drains the ring, then takes two or three passes of the shared divider
// (tail slot index, link delay, new slot index).
// Throughput: one word at a time in the back end; the front queue holds two more.
// Reset: synchronous, active low; clears the ring, counters and queue, and loads the register defaults.
module link_bandwidth_queue_emulator
    import lbqe_pkg::*;
#(
    parameter int QUEUE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // now_tick[31:0], packet_len[47:32], random_word[78:48]
    input  logic [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // dropped, drop_cause, schedule_tick, zero_delay, queue_depth, queued_bytes
    output logic [8*((60+$clog2(QUEUE_SLOTS+1)+7)/8)-1:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int OUT_W = 60 + CNT_W;
    localparam int OUT_B = 8 * ((OUT_W + 7) / 8);

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             item_valid, pop;
    t_item            item;
    t_result          result;
    logic [CNT_W-1:0] depth;
    logic [23:0]      bytes_q;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{loss_threshold: '0, rate_kbps: '0, bytes_per_tick: '0,
                       queue_limit: 9'd256, ticks_per_second: 16'd1000,
                       prop_delay_ticks: '0, include_delay: 1'b1};
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_LOSS_THRESHOLD:   r_cfg.loss_threshold   <= pwdata[30:0];
                REG_RATE_KBPS:        r_cfg.rate_kbps        <= pwdata[23:0];
                REG_BYTES_PER_TICK:   r_cfg.bytes_per_tick   <= pwdata[23:0];
                REG_QUEUE_LIMIT:      r_cfg.queue_limit      <= pwdata[8:0];
                REG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= pwdata[15:0];
                REG_PROP_DELAY_TICKS: r_cfg.prop_delay_ticks <= pwdata[15:0];
                REG_INCLUDE_DELAY:    r_cfg.include_delay    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LOSS_THRESHOLD:   prdata = 32'(r_cfg.loss_threshold);
            REG_RATE_KBPS:        prdata = 32'(r_cfg.rate_kbps);
            REG_BYTES_PER_TICK:   prdata = 32'(r_cfg.bytes_per_tick);
            REG_QUEUE_LIMIT:      prdata = 32'(r_cfg.queue_limit);
            REG_TICKS_PER_SECOND: prdata = 32'(r_cfg.ticks_per_second);
            REG_PROP_DELAY_TICKS: prdata = 32'(r_cfg.prop_delay_ticks);
            REG_INCLUDE_DELAY:    prdata = 32'(r_cfg.include_delay);
            default:              prdata = 32'd0;
        endcase
    end

    lbqe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_func       (s_axis_tuser[0]),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    lbqe_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result),
        .o_depth      (depth),
        .o_bytes      (bytes_q)
    );

    assign m_axis_tdata = OUT_B'({bytes_q, depth, result.zero_delay, result.schedule_tick,
                                  result.drop_cause, result.dropped});

endmodule
